@@ sv/imc_pkg.sv @@
`default_nettype none

package imc_pkg;

    // Command codes carried in the request tuser
    localparam logic [2:0] CMD_READ     = 3'd0;
    localparam logic [2:0] CMD_WRITE    = 3'd1;
    localparam logic [2:0] CMD_REPLY    = 3'd2;
    localparam logic [2:0] CMD_RAW      = 3'd3;
    localparam logic [2:0] CMD_SET_ADDR = 3'd4;

    // Result kinds
    localparam logic [2:0] KIND_FRAME = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_DONE  = 3'd2;
    localparam logic [2:0] KIND_RAW   = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_POLL_A  = 3'd1;
    localparam logic [2:0] REG_POLL_B  = 3'd2;
    localparam logic [2:0] REG_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_PERIOD  = 3'd4;

    localparam logic [7:0]  HIGH_BYTE_FLAG = 8'h08;
    localparam logic [7:0]  POLL_FLIP      = 8'h60;
    localparam logic [16:0] ELAPSED_MAX    = 17'h1ffff;

    localparam logic [1:0] MODE_FLASH_READ  = 2'd0;
    localparam logic [1:0] MODE_EEPROM_READ = 2'd1;
    localparam logic [1:0] MODE_FLASH_WRITE = 2'd2;

    typedef struct packed {
        logic [1:0]  memory_mode;
        logic [7:0]  poll_value_a;
        logic [7:0]  poll_value_b;
        logic [15:0] poll_timeout;
        logic [7:0]  clock_period;
    } t_cfg;

    // Frame opcode for each memory mode
    function automatic logic [7:0] mode_opcode(input logic [1:0] mode);
        logic [7:0] op;
        case (mode)
            MODE_FLASH_READ:  op = 8'h20;
            MODE_EEPROM_READ: op = 8'ha0;
            MODE_FLASH_WRITE: op = 8'h40;
            default:          op = 8'hc0;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

@@ sv/imc_regs.sv @@
`default_nettype none

module imc_regs
    import imc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.memory_mode  <= 2'd0;
            r_cfg.poll_value_a <= 8'd0;
            r_cfg.poll_value_b <= 8'd0;
            r_cfg.poll_timeout <= 16'd0;
            r_cfg.clock_period <= 8'd1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:    r_cfg.memory_mode  <= pwdata[1:0];
                REG_POLL_A:  r_cfg.poll_value_a <= pwdata[7:0];
                REG_POLL_B:  r_cfg.poll_value_b <= pwdata[7:0];
                REG_TIMEOUT: r_cfg.poll_timeout <= pwdata[15:0];
                REG_PERIOD:  r_cfg.clock_period <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (reg_idx)
            REG_MODE:    prdata = {30'd0, r_cfg.memory_mode};
            REG_POLL_A:  prdata = {24'd0, r_cfg.poll_value_a};
            REG_POLL_B:  prdata = {24'd0, r_cfg.poll_value_b};
            REG_TIMEOUT: prdata = {16'd0, r_cfg.poll_timeout};
            REG_PERIOD:  prdata = {24'd0, r_cfg.clock_period};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/isp_memory_command_engine.sv @@
`default_nettype none

// Serial programming command engine for target flash and EEPROM.
// Requests arrive on the s_ stream: a command in s_tuser selects a byte read,
// a byte write, a target reply, a raw frame or an address load. Results leave
// on the m_ stream: frames to shift to the target, read bytes for the host,
// write-finished notices, raw replies and sequence errors.
// Each request is handled in a single pass: the result is in the output register
// the cycle after acceptance, and a new request can be taken every cycle while
// no result is held back by m_tready. The single pass from input to output register (frame
// build, address step, poll compare and saturating time add) sets this.
// Unknown commands give no result; address loads give none unless a reply is awaited.
// While a result waits in the output register and m_tready is low, s_tready
// drops; it rises again in the cycle the result is taken.
// Reset clears the address counter, the pending phase, the last written byte,
// the poll state and the output valid flag; registers return to their reset
// values (clock period 1, all others 0). Registers are written over the APB
// port at byte address 4 * index, pready is always high.
module isp_memory_command_engine
    import imc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: write_byte[7:0], start_address[23:8], raw_frame[55:24], reply_frame[87:56]
    input  wire logic [87:0] s_tdata,
    // tuser: opcode[2:0], raw_single[3]
    input  wire logic [3:0]  s_tuser,
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: frame_out[31:0], host_byte[39:32], raw_reply[71:40]
    output logic [71:0]      m_tdata,
    // tuser: result_kind[2:0], frame_single[3], timed_out[4]
    output logic [4:0]       m_tuser,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_READ,
        PH_WRITE,
        PH_POLL,
        PH_RAW4,
        PH_RAW1
    } t_phase;

    t_cfg cfg;

    imc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Engine state
    t_phase      r_phase,  n_phase;
    logic [15:0] r_addr,   n_addr;
    logic [7:0]  r_last,   n_last;
    logic [7:0]  r_pop,    n_pop;
    logic [15:0] r_pfa,    n_pfa;
    logic [16:0] r_elap,   n_elap;

    // Output register
    logic        r_valid;
    logic [2:0]  r_kind,   n_kind;
    logic [31:0] r_frame,  n_frame;
    logic        r_single, n_single;
    logic [7:0]  r_hbyte,  n_hbyte;
    logic [31:0] r_raw,    n_raw;
    logic        r_tmo,    n_tmo;
    logic        n_emit;

    // Request fields
    logic [2:0]  in_opc;
    logic        in_rs;
    logic [7:0]  in_wb;
    logic [15:0] in_sa;
    logic [31:0] in_raw;
    logic [31:0] in_reply;
    logic        accept;

    assign in_wb    = s_tdata[7:0];
    assign in_sa    = s_tdata[23:8];
    assign in_raw   = s_tdata[55:24];
    assign in_reply = s_tdata[87:56];
    assign in_opc   = s_tuser[2:0];
    assign in_rs    = s_tuser[3];

    assign s_tready = !r_valid || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = r_valid;
    assign m_tdata  = {r_raw, r_hbyte, r_frame};
    assign m_tuser  = {r_tmo, r_single, r_kind};

    // Memory frame for the current address
    logic [7:0]  fr_op;
    logic [15:0] fr_a;
    logic [15:0] fr_fa;
    logic [31:0] fr_word;

    always_comb begin
        fr_op = mode_opcode(cfg.memory_mode);
        fr_a  = r_addr;
        if (fr_op[7]) begin
            fr_a = {r_addr[14:0], 1'b0};
        end
        if (fr_a[0]) begin
            fr_op = fr_op | HIGH_BYTE_FLAG;
        end
        fr_fa   = {1'b0, fr_a[15:1]};
        fr_word = {fr_op, fr_fa, r_last};
    end

    // Poll bookkeeping
    logic [7:0]  rep_byte;
    logic [17:0] elap_sum;
    logic [16:0] elap_sat;
    logic        poll_match;
    logic        poll_expired;
    logic [31:0] poll_word;

    assign rep_byte     = in_reply[7:0];
    assign elap_sum     = {1'b0, r_elap} + {5'd0, cfg.clock_period, 5'd0};
    assign elap_sat     = elap_sum[17] ? ELAPSED_MAX : elap_sum[16:0];
    assign poll_match   = (rep_byte == r_last) && (rep_byte != cfg.poll_value_a)
                          && (rep_byte != cfg.poll_value_b);
    assign poll_expired = elap_sat >= {1'b0, cfg.poll_timeout};
    assign poll_word    = {r_pop, r_pfa, r_last};

    // Next state and result for one request
    always_comb begin
        n_phase  = r_phase;
        n_addr   = r_addr;
        n_last   = r_last;
        n_pop    = r_pop;
        n_pfa    = r_pfa;
        n_elap   = r_elap;
        n_emit   = 1'b0;
        n_kind   = KIND_FRAME;
        n_frame  = 32'd0;
        n_single = 1'b0;
        n_hbyte  = 8'd0;
        n_raw    = 32'd0;
        n_tmo    = 1'b0;

        if (in_opc == CMD_REPLY) begin
            n_emit = 1'b1;
            unique case (r_phase)
                PH_READ: begin
                    n_phase = PH_IDLE;
                    n_kind  = KIND_READ;
                    n_hbyte = rep_byte;
                end
                PH_WRITE: begin
                    if (cfg.poll_timeout == 16'd0) begin
                        n_phase = PH_IDLE;
                        n_kind  = KIND_DONE;
                    end else begin
                        n_elap  = 17'd0;
                        n_phase = PH_POLL;
                        n_frame = poll_word;
                    end
                end
                PH_POLL: begin
                    if (poll_match) begin
                        n_phase = PH_IDLE;
                        n_kind  = KIND_DONE;
                    end else begin
                        n_elap = elap_sat;
                        if (poll_expired) begin
                            n_phase = PH_IDLE;
                            n_kind  = KIND_DONE;
                            n_tmo   = 1'b1;
                        end else begin
                            n_frame = poll_word;
                        end
                    end
                end
                PH_RAW4: begin
                    n_phase = PH_IDLE;
                    n_kind  = KIND_RAW;
                    n_raw   = in_reply;
                end
                PH_RAW1: begin
                    n_phase = PH_IDLE;
                    n_kind  = KIND_RAW;
                    n_raw   = {24'd0, rep_byte};
                end
                default: begin
                    n_kind = KIND_ERROR;
                end
            endcase
        end else if (in_opc <= CMD_SET_ADDR) begin
            if (r_phase != PH_IDLE) begin
                // Command while a reply is still awaited
                n_emit = 1'b1;
                n_kind = KIND_ERROR;
            end else begin
                unique case (in_opc)
                    CMD_READ: begin
                        n_emit  = 1'b1;
                        n_frame = fr_word;
                        n_addr  = r_addr + 16'd1;
                        n_phase = PH_READ;
                    end
                    CMD_WRITE: begin
                        n_emit  = 1'b1;
                        n_last  = in_wb;
                        n_frame = {fr_op, fr_fa, in_wb};
                        n_addr  = r_addr + 16'd1;
                        n_pop   = fr_op ^ POLL_FLIP;
                        n_pfa   = fr_fa;
                        n_elap  = 17'd0;
                        n_phase = PH_WRITE;
                    end
                    CMD_RAW: begin
                        n_emit = 1'b1;
                        if (in_rs) begin
                            n_phase  = PH_RAW1;
                            n_frame  = {24'd0, in_raw[7:0]};
                            n_single = 1'b1;
                        end else begin
                            n_phase = PH_RAW4;
                            n_frame = in_raw;
                        end
                    end
                    default: begin
                        n_addr = in_sa;
                    end
                endcase
            end
        end
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_addr  <= 16'd0;
            r_last  <= 8'd0;
            r_pop   <= 8'd0;
            r_pfa   <= 16'd0;
            r_elap  <= 17'd0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_addr  <= n_addr;
                r_last  <= n_last;
                r_pop   <= n_pop;
                r_pfa   <= n_pfa;
                r_elap  <= n_elap;
            end
            if (accept && n_emit) begin
                r_valid <= 1'b1;
            end else if (m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_kind   <= n_kind;
            r_frame  <= n_frame;
            r_single <= n_single;
            r_hbyte  <= n_hbyte;
            r_raw    <= n_raw;
            r_tmo    <= n_tmo;
        end
    end

    // Checks
    a_tmo_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_tmo) |-> (r_kind == KIND_DONE))
        else $error("timeout flag on a result that is not write finished");

    a_single_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_single) |-> ((r_kind == KIND_FRAME) && (r_frame[31:8] == 24'd0)))
        else $error("single-byte flag on a malformed result");

    a_read_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_phase == PH_IDLE) && (in_opc == CMD_READ)) |=> (r_phase == PH_READ))
        else $error("read frame sent without awaiting its reply");

    a_reply_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_opc == CMD_REPLY) && (r_phase == PH_READ))
        |=> (r_phase == PH_IDLE) && r_valid && (r_kind == KIND_READ))
        else $error("read reply not returned to host");

endmodule

`default_nettype wire

@@ bench/imc_checker.sv @@
// Watches the request, result and register ports of the command engine,
// predicts every result from its own copy of the engine state and compares.
module imc_checker
    import imc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // tdata: write_byte[7:0], start_address[23:8], raw_frame[55:24], reply_frame[87:56]
    input  wire logic [87:0] i_s_tdata,
    // tuser: opcode[2:0], raw_single[3]
    input  wire logic [3:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // tdata: frame_out[31:0], host_byte[39:32], raw_reply[71:40]
    input  wire logic [71:0] i_m_tdata,
    // tuser: result_kind[2:0], frame_single[3], timed_out[4]
    input  wire logic [4:0]  i_m_tuser,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [4:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Frame opcodes per memory mode, mode 0 in the low byte
    localparam logic [31:0] FRAME_OPCODES = {8'hc0, 8'h40, 8'ha0, 8'h20};

    typedef enum logic [2:0] {
        WAIT_NONE, WAIT_READ, WAIT_WRITE, WAIT_POLL, WAIT_RAW4, WAIT_RAW1
    } t_wait;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] frame;
        logic        single;
        logic [7:0]  host;
        logic [31:0] raw;
        logic        timed_out;
    } t_engine_result;

    t_engine_result expected_results[$];

    // Register copy and engine state
    t_cfg        cfg;
    t_wait       awaiting;
    logic [15:0] address_count;
    logic [7:0]  last_written;
    logic [7:0]  poll_op;
    logic [15:0] poll_addr;
    logic [16:0] elapsed;

    task automatic queue_result(input logic [2:0] kind, input logic [31:0] frame,
                                input logic single, input logic [7:0] host,
                                input logic [31:0] raw, input logic timed_out);
        expected_results.push_back('{kind, frame, single, host, raw, timed_out});
    endtask

    function automatic logic [31:0] poll_word();
        return {poll_op, poll_addr, last_written};
    endfunction

    // Memory frame at the current address; steps the address
    task automatic next_memory_frame(output logic [31:0] frame, output logic [7:0] op,
                                     output logic [15:0] word_addr);
        logic [15:0] a;
        op = FRAME_OPCODES[cfg.memory_mode*8 +: 8];
        a = address_count;
        address_count = address_count + 16'd1;
        // EEPROM: byte address shifted up, so the high-byte flag stays clear
        if (op[7]) a = a << 1;
        if (a[0]) op = op | HIGH_BYTE_FLAG;
        word_addr = a >> 1;
        frame = {op, word_addr, last_written};
    endtask

    task automatic predict_engine_response(input logic [2:0] cmd, input logic [7:0] wr_byte,
                                           input logic [15:0] start_addr,
                                           input logic [31:0] raw_word, input logic raw_one,
                                           input logic [31:0] reply_word);
        logic [31:0] frame;
        logic [7:0]  op;
        logic [15:0] word_addr;
        logic [7:0]  rb;
        logic [17:0] sum;
        rb = reply_word[7:0];
        if (cmd > CMD_SET_ADDR) return;
        if (cmd == CMD_REPLY) begin
            case (awaiting)
                WAIT_READ: begin
                    awaiting = WAIT_NONE;
                    queue_result(KIND_READ, 32'd0, 1'b0, rb, 32'd0, 1'b0);
                end
                WAIT_WRITE: begin
                    if (cfg.poll_timeout == 16'd0) begin
                        awaiting = WAIT_NONE;
                        queue_result(KIND_DONE, 32'd0, 1'b0, 8'd0, 32'd0, 1'b0);
                    end else begin
                        elapsed = '0;
                        awaiting = WAIT_POLL;
                        queue_result(KIND_FRAME, poll_word(), 1'b0, 8'd0, 32'd0, 1'b0);
                    end
                end
                WAIT_POLL: begin
                    if (rb == last_written && rb != cfg.poll_value_a &&
                        rb != cfg.poll_value_b) begin
                        awaiting = WAIT_NONE;
                        queue_result(KIND_DONE, 32'd0, 1'b0, 8'd0, 32'd0, 1'b0);
                    end else begin
                        // each poll adds its cost, set by the clock period register, saturating
                        sum = {1'b0, elapsed} + {5'd0, cfg.clock_period, 5'd0};
                        elapsed = (sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : sum[16:0];
                        if (elapsed >= {1'b0, cfg.poll_timeout}) begin
                            awaiting = WAIT_NONE;
                            queue_result(KIND_DONE, 32'd0, 1'b0, 8'd0, 32'd0, 1'b1);
                        end else begin
                            queue_result(KIND_FRAME, poll_word(), 1'b0, 8'd0, 32'd0, 1'b0);
                        end
                    end
                end
                WAIT_RAW4: begin
                    awaiting = WAIT_NONE;
                    queue_result(KIND_RAW, 32'd0, 1'b0, 8'd0, reply_word, 1'b0);
                end
                WAIT_RAW1: begin
                    awaiting = WAIT_NONE;
                    queue_result(KIND_RAW, 32'd0, 1'b0, 8'd0, {24'd0, rb}, 1'b0);
                end
                default: queue_result(KIND_ERROR, 32'd0, 1'b0, 8'd0, 32'd0, 1'b0);
            endcase
        end else if (awaiting != WAIT_NONE) begin
            // command while a reply is due: refused, reply still awaited
            queue_result(KIND_ERROR, 32'd0, 1'b0, 8'd0, 32'd0, 1'b0);
        end else begin
            case (cmd)
                CMD_READ: begin
                    next_memory_frame(frame, op, word_addr);
                    awaiting = WAIT_READ;
                    queue_result(KIND_FRAME, frame, 1'b0, 8'd0, 32'd0, 1'b0);
                end
                CMD_WRITE: begin
                    last_written = wr_byte;
                    next_memory_frame(frame, op, word_addr);
                    poll_op = op ^ POLL_FLIP;
                    poll_addr = word_addr;
                    elapsed = '0;
                    awaiting = WAIT_WRITE;
                    queue_result(KIND_FRAME, frame, 1'b0, 8'd0, 32'd0, 1'b0);
                end
                CMD_RAW: begin
                    if (raw_one) begin
                        awaiting = WAIT_RAW1;
                        queue_result(KIND_FRAME, {24'd0, raw_word[7:0]}, 1'b1, 8'd0, 32'd0,
                                     1'b0);
                    end else begin
                        awaiting = WAIT_RAW4;
                        queue_result(KIND_FRAME, raw_word, 1'b0, 8'd0, 32'd0, 1'b0);
                    end
                end
                default: address_count = start_addr;
            endcase
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // Sample all ports at the rising edge
    always @(posedge i_clk) begin
        t_engine_result want;
        t_engine_result got;
        if (!i_rst_n) begin
            cfg = '{memory_mode: 2'd0, poll_value_a: 8'd0, poll_value_b: 8'd0,
                    poll_timeout: 16'd0, clock_period: 8'd1};
            awaiting = WAIT_NONE;
            address_count = '0;
            last_written = '0;
            poll_op = '0;
            poll_addr = '0;
            elapsed = '0;
            expected_results.delete();
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_MODE:    cfg.memory_mode  = i_pwdata[1:0];
                    REG_POLL_A:  cfg.poll_value_a = i_pwdata[7:0];
                    REG_POLL_B:  cfg.poll_value_b = i_pwdata[7:0];
                    REG_TIMEOUT: cfg.poll_timeout = i_pwdata[15:0];
                    REG_PERIOD:  cfg.clock_period = i_pwdata[7:0];
                    default: ;
                endcase
            end
            // results
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tuser[2:0], i_m_tdata[31:0], i_m_tuser[3], i_m_tdata[39:32],
                        i_m_tdata[71:40], i_m_tuser[4]};
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result with nothing expected, kind 0x%0h data 0x%0h",
                             $time, got.kind, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    report_field("result_kind", 32'(want.kind), 32'(got.kind));
                    report_field("frame_out", want.frame, got.frame);
                    report_field("frame_single", 32'(want.single), 32'(got.single));
                    report_field("host_byte", 32'(want.host), 32'(got.host));
                    report_field("raw_reply", want.raw, got.raw);
                    report_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
                end
            end
            // requests
            if (i_s_tvalid && i_s_tready)
                predict_engine_response(i_s_tuser[2:0], i_s_tdata[7:0], i_s_tdata[23:8],
                                        i_s_tdata[55:24], i_s_tuser[3], i_s_tdata[87:56]);
        end
        o_pending = expected_results.size();
    end

endmodule

@@ bench/tb_top.sv @@
// Stimulus and verdict for the serial programming command engine.
module tb_top;
    import imc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_EEPROM_WRITE = 2'd3;
    localparam int         CYCLE_LIMIT       = 400000;
    localparam int         PHASE_ITEMS       = 120;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [71:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          items_sent = 0;
    logic [7:0]  cur_pva;
    logic [7:0]  cur_pvb;
    logic [7:0]  cur_period;

    isp_memory_command_engine u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    imc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side back-pressure
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One request: optional idle gap, then hold until accepted
    task automatic send_request(input logic [2:0] cmd, input logic [7:0] wr_byte,
                                input logic [15:0] start_addr, input logic [31:0] raw_word,
                                input logic raw_one, input logic [31:0] reply_word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {reply_word, raw_word, start_addr, wr_byte};
        s_tuser  <= {raw_one, cmd};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (cmd <= CMD_SET_ADDR) items_sent++;
    endtask

    task automatic reply_with(input logic [7:0] low);
        send_request(CMD_REPLY, 8'($urandom), 16'($urandom), $urandom, 1'($urandom),
                     {24'($urandom), low});
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [1:0] mode, input logic [7:0] pva,
                                  input logic [7:0] pvb, input logic [15:0] tmo,
                                  input logic [7:0] period);
        write_reg(REG_MODE, {30'd0, mode});
        write_reg(REG_POLL_A, {24'd0, pva});
        write_reg(REG_POLL_B, {24'd0, pvb});
        write_reg(REG_TIMEOUT, {16'd0, tmo});
        write_reg(REG_PERIOD, {24'd0, period});
        cur_pva    = pva;
        cur_pvb    = pvb;
        cur_period = period;
    endtask

    // Wait for every outstanding result, then let the pipeline drain
    task automatic settle();
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // One mostly well-formed exchange with random content
    task automatic run_sequence();
        int         pick;
        int         polls;
        logic [7:0] wb;
        logic       matched;
        pick = $urandom_range(99);
        if (pick < 25) begin
            send_request(CMD_READ, 8'($urandom), 16'($urandom), $urandom, 1'($urandom),
                         $urandom);
            reply_with(8'($urandom));
        end else if (pick < 60) begin
            wb = 8'($urandom);
            // with no time budget growth only a clean read-back ends polling
            if (cur_period == 8'd0)
                while (wb == cur_pva || wb == cur_pvb) wb = 8'($urandom);
            send_request(CMD_WRITE, wb, 16'($urandom), $urandom, 1'($urandom), $urandom);
            reply_with(8'($urandom));
            polls = $urandom_range(1, 20);
            matched = 1'b0;
            for (int i = 0; i < polls && !matched; i++) begin
                pick = $urandom_range(99);
                if (pick < 25) begin
                    reply_with(wb);
                    matched = 1'b1;
                end else if (pick < 45) begin
                    reply_with(cur_pva);
                end else if (pick < 60) begin
                    reply_with(cur_pvb);
                end else begin
                    reply_with(8'($urandom));
                end
            end
            if (!matched) reply_with(wb);
        end else if (pick < 75) begin
            send_request(CMD_RAW, 8'($urandom), 16'($urandom), $urandom, 1'($urandom),
                         $urandom);
            reply_with(8'($urandom));
        end else if (pick < 87) begin
            send_request(CMD_SET_ADDR, 8'($urandom),
                         ($urandom_range(4) == 0) ? 16'hffff - 16'($urandom_range(3))
                                                  : 16'($urandom),
                         $urandom, 1'($urandom), $urandom);
        end else begin
            // noise: any code, including unknown ones and stray replies
            send_request(3'($urandom_range(7)), 8'($urandom), 16'($urandom), $urandom,
                         1'($urandom), $urandom);
        end
    endtask

    initial begin
        cur_pva    = 8'd0;
        cur_pvb    = 8'd0;
        cur_period = 8'd1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset settings, flash read mode, zero timeout
        send_request(CMD_SET_ADDR, 8'h00, 16'hffff, 32'h0, 1'b0, 32'h0);
        send_request(CMD_READ, 8'hff, 16'h0000, 32'hffffffff, 1'b1, 32'h0);
        reply_with(8'hff);
        // counter has wrapped to zero
        send_request(CMD_READ, 8'h00, 16'hffff, 32'h0, 1'b0, 32'hffffffff);
        reply_with(8'h00);
        // reply with nothing pending
        reply_with(8'h3c);
        // write in a read mode, finishes at its reply
        send_request(CMD_WRITE, 8'hff, 16'h0, 32'h0, 1'b0, 32'h0);
        reply_with(8'h00);
        // commands while a reply is due
        send_request(CMD_READ, 8'h00, 16'h0, 32'h0, 1'b0, 32'h0);
        send_request(CMD_READ, 8'h00, 16'h0, 32'h0, 1'b0, 32'h0);
        send_request(CMD_SET_ADDR, 8'h00, 16'h1234, 32'h0, 1'b0, 32'h0);
        send_request(CMD_RAW, 8'h00, 16'h0, 32'hdeadbeef, 1'b0, 32'h0);
        reply_with(8'h81);
        // raw single byte and raw four bytes
        send_request(CMD_RAW, 8'h00, 16'h0, 32'hffffffa5, 1'b1, 32'h0);
        send_request(CMD_REPLY, 8'h00, 16'h0, 32'h0, 1'b0, 32'hffffffff);
        send_request(CMD_RAW, 8'h00, 16'h0, 32'hffffffff, 1'b0, 32'h0);
        send_request(CMD_REPLY, 8'h00, 16'h0, 32'h0, 1'b0, 32'h12345678);
        // unknown codes are dropped
        send_request(3'd5, 8'hff, 16'hffff, 32'hffffffff, 1'b1, 32'hffffffff);
        send_request(3'd7, 8'h00, 16'h0, 32'h0, 1'b0, 32'h0);
        s_tvalid <= 1'b0;
        settle();

        // Directed: EEPROM write with polling, busy value then clean read-back
        apply_settings(MODE_EEPROM_WRITE, 8'hff, 8'h00, 16'hffff, 8'hff);
        send_request(CMD_WRITE, 8'h5a, 16'h0, 32'h0, 1'b0, 32'h0);
        reply_with(8'h00);
        reply_with(8'hff);
        reply_with(8'h5a);
        s_tvalid <= 1'b0;
        settle();

        // Random phases, each with its own settings and idling
        for (int p = 0; p < 7; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            case (p)
                0: apply_settings(MODE_FLASH_WRITE, 8'hff, 8'h00, 16'd500, 8'd1);
                1: apply_settings(MODE_EEPROM_WRITE, 8'hff, 8'hff, 16'd200, 8'd2);
                2: apply_settings(MODE_FLASH_READ, 8'h00, 8'h7f, 16'd0, 8'hff);
                3: apply_settings(MODE_EEPROM_READ, 8'h80, 8'h01, 16'hffff, 8'hff);
                4: apply_settings(MODE_FLASH_WRITE, 8'haa, 8'h55, 16'd100, 8'd0);
                5: apply_settings(MODE_EEPROM_WRITE, 8'h00, 8'hff, 16'd1, 8'd1);
                default: apply_settings(2'($urandom), 8'($urandom), 8'($urandom),
                                        16'($urandom_range(4000)), 8'($urandom_range(1, 40)));
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) run_sequence();
            s_tvalid <= 1'b0;
            settle();
        end

        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
